>>> rtl/poly_voice_allocator_assert.svh
// ----------------------------------------------------------------------------
// poly_voice_allocator assertion macros
// Shared property forms for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pva assertion failed");

// next-cycle implication, disabled in reset
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pva assertion failed");

`endif

>>> rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and codes of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_PEDAL    = 2'd2,
        OP_REL_DONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_FREE      = 2'd1,
        KIND_RELEASING = 2'd2,
        KIND_STOLEN    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_PSCAN
    } t_state;

    typedef struct packed {
        logic load;    // request accepted, latch fields
        logic scan;    // note search over all voices
        logic pscan;   // pedal release sweep
        logic commit;  // apply note on / note off
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic commit_done;
    } t_sts;

endpackage

>>> rtl/pva_ctrl.sv
// ----------------------------------------------------------------------------
// pva_ctrl
// Sequencer of the voice allocator: request intake, scans and commit.
// ----------------------------------------------------------------------------
module pva_ctrl import pva_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic       i_pedal_down,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_opcode'(i_opcode))
                        OP_NOTE_ON, OP_NOTE_OFF: n_state = ST_SCAN;
                        OP_PEDAL:                n_state = i_pedal_down ? ST_IDLE : ST_PSCAN;
                        default:                 n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_sts.commit_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PSCAN: begin
                o_cmd.pscan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/pva_datapath.sv
// ----------------------------------------------------------------------------
// pva_datapath
// Voice state, note/age memories, scan pipeline and result register.
// ----------------------------------------------------------------------------
module pva_datapath import pva_pkg::*; #(
    parameter int NUM_VOICES = 16,
    parameter int AGE_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [1:0] i_opcode,
    input  logic [6:0] i_note_number,
    input  logic [6:0] i_velocity,
    input  logic       i_pedal_down,
    input  logic [3:0] i_silent_voice,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_voice_index,
    output logic [6:0] o_note_out,
    output logic [6:0] o_velocity_out,
    output logic       o_gate,
    output logic [1:0] o_alloc_kind,
    output logic       o_last
);

    localparam int                IDX_W    = $clog2(NUM_VOICES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_VOICES - 1);
    localparam logic [7:0]        NV_LIMIT = 8'(NUM_VOICES);

    // per-voice flags, pedal and age clock
    logic [NUM_VOICES-1:0] r_active;
    logic [NUM_VOICES-1:0] r_releasing;
    logic [NUM_VOICES-1:0] r_sustained;
    logic [NUM_VOICES-1:0] r_age_vld;
    logic                  r_pedal;
    logic [AGE_BITS-1:0]   r_age_clock;

    // note and age storage
    logic [6:0]          note_mem [NUM_VOICES];
    logic [AGE_BITS-1:0] age_mem  [NUM_VOICES];
    logic [6:0]          r_rd_note;
    logic [AGE_BITS-1:0] r_rd_age;

    // latched request
    t_opcode    r_op;
    logic [6:0] r_note;
    logic [6:0] r_vel;

    // scan pipeline
    logic [IDX_W-1:0] r_idx;
    logic             r_iss_done;
    logic             r_ev_vld;
    logic [IDX_W-1:0] r_ev_idx;
    logic [IDX_W-1:0] rd_addr;

    // search results
    logic                r_hit_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_rel_found;
    logic [IDX_W-1:0]    r_rel_idx;
    logic                r_min_found;
    logic [IDX_W-1:0]    r_min_idx;
    logic [AGE_BITS-1:0] r_min_age;

    logic                r_out_vld;

    logic                scan_en;
    logic                sc_ev;
    logic                ev_match;
    logic [AGE_BITS-1:0] ev_age;
    logic                pscan_hit;
    logic                stall;
    logic                p_emit;
    logic                out_free;
    logic                need_emit;
    logic                c_fire;
    logic                c_emit;
    logic                emit;
    logic                any_above;
    logic [IDX_W-1:0]    sel_idx;
    t_kind               sel_kind;
    logic [7:0]          silent_ext;
    logic [IDX_W-1:0]    silent_idx;
    logic                silent_ok;
    t_opcode             in_op;

    logic [IDX_W-1:0]    n_out_idx;
    logic [IDX_W+3:0]    out_idx_ext;
    logic [6:0]          n_out_note;
    logic [6:0]          n_out_vel;
    logic                n_out_gate;
    t_kind               n_out_kind;
    logic                n_out_last;

    assign in_op      = t_opcode'(i_opcode);
    assign silent_ext = {4'b0, i_silent_voice};
    assign silent_idx = silent_ext[IDX_W-1:0];
    assign silent_ok  = (silent_ext < NV_LIMIT);

    assign out_free   = !r_out_vld || i_out_ready;
    assign scan_en    = i_cmd.scan || i_cmd.pscan;
    assign sc_ev      = i_cmd.scan && r_ev_vld;
    assign ev_match   = r_active[r_ev_idx] && (r_rd_note == r_note);
    assign ev_age     = r_age_vld[r_ev_idx] ? r_rd_age : '0;

    assign pscan_hit  = i_cmd.pscan && r_ev_vld && r_sustained[r_ev_idx];
    assign stall      = pscan_hit && !out_free;
    assign p_emit     = pscan_hit && out_free;

    assign need_emit  = (r_op == OP_NOTE_ON) ||
                        ((r_op == OP_NOTE_OFF) && r_hit_found && !r_pedal);
    assign c_fire     = i_cmd.commit && (!need_emit || out_free);
    assign c_emit     = c_fire && need_emit;
    assign emit       = c_emit || p_emit;

    assign rd_addr    = stall ? r_ev_idx : r_idx;

    assign o_sts.scan_done   = r_ev_vld && r_iss_done && (r_ev_idx == LAST_IDX) && !stall;
    assign o_sts.commit_done = c_fire;

    // voice choice: retrigger, free, releasing, oldest
    always_comb begin
        if (r_hit_found) begin
            sel_idx  = r_hit_idx;
            sel_kind = KIND_NONE;
        end else if (r_free_found) begin
            sel_idx  = r_free_idx;
            sel_kind = KIND_FREE;
        end else if (r_rel_found) begin
            sel_idx  = r_rel_idx;
            sel_kind = KIND_RELEASING;
        end else begin
            sel_idx  = r_min_idx;
            sel_kind = KIND_STOLEN;
        end
    end

    // any sustained voice still ahead of the sweep
    always_comb begin
        any_above = 1'b0;
        for (int j = 0; j < NUM_VOICES; j++) begin
            if ((IDX_W'(j) > r_ev_idx) && r_sustained[j]) begin
                any_above = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_iss_done <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_ev_idx   <= '0;
        end else if (i_cmd.load) begin
            r_idx      <= '0;
            r_iss_done <= 1'b0;
            r_ev_vld   <= 1'b0;
        end else if (scan_en && !stall) begin
            if (!r_iss_done) begin
                r_ev_vld <= 1'b1;
                r_ev_idx <= r_idx;
                if (r_idx == LAST_IDX) begin
                    r_iss_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_ev_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit && (r_op == OP_NOTE_ON)) begin
            note_mem[sel_idx] <= r_note;
            age_mem[sel_idx]  <= r_age_clock;
        end
        r_rd_note <= note_mem[rd_addr];
        r_rd_age  <= age_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_releasing <= '0;
            r_sustained <= '0;
            r_age_vld   <= '0;
            r_pedal     <= 1'b0;
            r_age_clock <= '0;
        end else begin
            if (i_cmd.load && (in_op == OP_PEDAL)) begin
                r_pedal <= i_pedal_down;
            end
            if (i_cmd.load && (in_op == OP_REL_DONE) && silent_ok) begin
                r_releasing[silent_idx] <= 1'b0;
            end
            if (c_emit && (r_op == OP_NOTE_ON)) begin
                r_active[sel_idx]    <= 1'b1;
                r_releasing[sel_idx] <= 1'b0;
                r_age_vld[sel_idx]   <= 1'b1;
                r_age_clock          <= r_age_clock + 1'b1;
            end
            if (c_fire && (r_op == OP_NOTE_OFF) && r_hit_found) begin
                if (r_pedal) begin
                    r_sustained[r_hit_idx] <= 1'b1;
                end else begin
                    r_active[r_hit_idx]    <= 1'b0;
                    r_releasing[r_hit_idx] <= 1'b1;
                end
            end
            if (p_emit) begin
                r_sustained[r_ev_idx] <= 1'b0;
                r_active[r_ev_idx]    <= 1'b0;
                r_releasing[r_ev_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= in_op;
            r_note       <= i_note_number;
            r_vel        <= i_velocity;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_rel_found  <= 1'b0;
            r_min_found  <= 1'b0;
        end else if (sc_ev) begin
            if (!r_hit_found && ev_match) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_ev_idx;
            end
            if (!r_free_found && !r_active[r_ev_idx] && !r_releasing[r_ev_idx]) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_ev_idx;
            end
            if (!r_rel_found && r_releasing[r_ev_idx]) begin
                r_rel_found <= 1'b1;
                r_rel_idx   <= r_ev_idx;
            end
            if (!r_min_found || (ev_age < r_min_age)) begin
                r_min_found <= 1'b1;
                r_min_age   <= ev_age;
                r_min_idx   <= r_ev_idx;
            end
        end
    end

    // result payload
    always_comb begin
        if (p_emit) begin
            n_out_idx  = r_ev_idx;
            n_out_note = r_active[r_ev_idx] ? r_rd_note : 7'd0;
            n_out_vel  = 7'd0;
            n_out_gate = 1'b0;
            n_out_kind = KIND_NONE;
            n_out_last = !any_above;
        end else if (r_op == OP_NOTE_ON) begin
            n_out_idx  = sel_idx;
            n_out_note = r_note;
            n_out_vel  = r_vel;
            n_out_gate = 1'b1;
            n_out_kind = sel_kind;
            n_out_last = 1'b1;
        end else begin
            n_out_idx  = r_hit_idx;
            n_out_note = r_note;
            n_out_vel  = 7'd0;
            n_out_gate = 1'b0;
            n_out_kind = KIND_NONE;
            n_out_last = 1'b1;
        end
        out_idx_ext = {4'b0, n_out_idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_voice_index  <= out_idx_ext[3:0];
            o_note_out     <= n_out_note;
            o_velocity_out <= n_out_vel;
            o_gate         <= n_out_gate;
            o_alloc_kind   <= n_out_kind;
            o_last         <= n_out_last;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

>>> rtl/poly_voice_allocator.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator
// Polyphonic voice allocator with oldest-note stealing.
// ----------------------------------------------------------------------------
// Requests come in on i_in_valid/o_in_ready: note on, note off, sustain
// pedal change, or release done for one voice. Results leave on
// o_out_valid/i_out_ready, one gate event each; o_last marks the final
// result of a request.
// Note on and note off sweep every voice through the note/age memory read
// port, one voice a cycle. A pedal release sweeps the same way, but holds
// while it waits on the receiver. Pedal press and release done need no
// sweep.
// The result register decouples the sides: a new request is taken while a
// result still waits. When the receiver stalls, a note on, or a note off
// that sends a gate-off, waits in its commit step and a sweep holds on the
// voice whose gate-off cannot be sent.
// Reset clears all voices to inactive, idle and unsustained, the age clock
// and the pedal; no clearing pass is needed.
// ----------------------------------------------------------------------------
module poly_voice_allocator import pva_pkg::*; #(
    parameter int NUM_VOICES = 16,
    parameter int AGE_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [6:0] i_note_number,
    input  logic [6:0] i_velocity,
    input  logic       i_pedal_down,
    input  logic [3:0] i_silent_voice,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_voice_index,
    output logic [6:0] o_note_out,
    output logic [6:0] o_velocity_out,
    output logic       o_gate,
    output logic [1:0] o_alloc_kind,
    output logic       o_last
);

    t_cmd cmd;
    t_sts sts;

    pva_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_pedal_down (i_pedal_down),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    pva_datapath #(
        .NUM_VOICES (NUM_VOICES),
        .AGE_BITS   (AGE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_opcode),
        .i_note_number  (i_note_number),
        .i_velocity     (i_velocity),
        .i_pedal_down   (i_pedal_down),
        .i_silent_voice (i_silent_voice),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_voice_index  (o_voice_index),
        .o_note_out     (o_note_out),
        .o_velocity_out (o_velocity_out),
        .o_gate         (o_gate),
        .o_alloc_kind   (o_alloc_kind),
        .o_last         (o_last)
    );

endmodule

>>> rtl/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_assert.svh"

module pva_checker import pva_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_opcode,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [6:0] o_velocity_out,
    input logic       o_gate,
    input logic [1:0] o_alloc_kind,
    input logic       o_last
);

    // pending result is not dropped
    `PVA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // note on request occupies the block for its search
    `PVA_ASSERT_NEXT(a_note_on_busy, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_opcode == OP_NOTE_ON), !o_in_ready)

    // gate on is always the single result of its request
    `PVA_ASSERT_IMPL(a_gate_on_last, i_clk, i_rst_n, o_out_valid && o_gate, o_last)

    // gate off carries no velocity and no allocation kind
    `PVA_ASSERT_IMPL(a_gate_off_clean, i_clk, i_rst_n, o_out_valid && !o_gate,
        (o_velocity_out == 7'd0) && (o_alloc_kind == KIND_NONE))

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_opcode       (i_opcode),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_velocity_out (o_velocity_out),
    .o_gate         (o_gate),
    .o_alloc_kind   (o_alloc_kind),
    .o_last         (o_last)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for poly_voice_allocator. A behavioral voice model runs
// beside the block and predicts every gate event from the accepted requests;
// a monitor compares each result field by field. Directed tests cover the
// field extremes, retrigger, sustain and voice stealing, then random request
// streams run under several idle and stall patterns, including a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb import pva_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VOICES   = 16;
    localparam int AGE_BITS     = 32;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [7:0] NOTE_IDLE = 8'hFF;

    typedef struct {
        logic [3:0] voice;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       gate;
        t_kind      kind;
        logic       last;
    } t_gate_event;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_opcode;
    logic [6:0] i_note_number;
    logic [6:0] i_velocity;
    logic       i_pedal_down;
    logic [3:0] i_silent_voice;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [3:0] o_voice_index;
    logic [6:0] o_note_out;
    logic [6:0] o_velocity_out;
    logic       o_gate;
    logic [1:0] o_alloc_kind;
    logic       o_last;

    // voice model
    logic [7:0]          vc_note      [NUM_VOICES];
    logic                vc_releasing [NUM_VOICES];
    logic                vc_sustained [NUM_VOICES];
    logic [AGE_BITS-1:0] vc_age       [NUM_VOICES];
    logic [AGE_BITS-1:0] age_counter;
    logic                pedal_held_m;

    t_gate_event pending_gate_events[$];

    int error_count;
    int cycle_count;
    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold;

    poly_voice_allocator #(
        .NUM_VOICES(NUM_VOICES),
        .AGE_BITS  (AGE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_note_number (i_note_number),
        .i_velocity    (i_velocity),
        .i_pedal_down  (i_pedal_down),
        .i_silent_voice(i_silent_voice),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_voice_index (o_voice_index),
        .o_note_out    (o_note_out),
        .o_velocity_out(o_velocity_out),
        .o_gate        (o_gate),
        .o_alloc_kind  (o_alloc_kind),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d gate events outstanding",
                     cycle_count, pending_gate_events.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: long hold-off first, random stalls otherwise
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        error_count++;
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin : check_gate_events
        t_gate_event exp_ev;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_gate_events.size() == 0) begin
                report_mismatch("unexpected result, voice", -1, o_voice_index);
            end else begin
                exp_ev = pending_gate_events.pop_front();
                if (o_voice_index !== exp_ev.voice)
                    report_mismatch("voice_index", exp_ev.voice, o_voice_index);
                if (o_note_out !== exp_ev.note)
                    report_mismatch("note_out", exp_ev.note, o_note_out);
                if (o_velocity_out !== exp_ev.velocity)
                    report_mismatch("velocity_out", exp_ev.velocity, o_velocity_out);
                if (o_gate !== exp_ev.gate)
                    report_mismatch("gate", exp_ev.gate, o_gate);
                if (o_alloc_kind !== exp_ev.kind)
                    report_mismatch("alloc_kind", exp_ev.kind, o_alloc_kind);
                if (o_last !== exp_ev.last)
                    report_mismatch("last", exp_ev.last, o_last);
            end
        end
    end

    function automatic void reset_voice_model();
        for (int i = 0; i < NUM_VOICES; i++) begin
            vc_note[i]      = NOTE_IDLE;
            vc_releasing[i] = 1'b0;
            vc_sustained[i] = 1'b0;
            vc_age[i]       = '0;
        end
        age_counter  = '0;
        pedal_held_m = 1'b0;
    endfunction

    function automatic void push_gate_event(input int v, input logic [6:0] vel,
                                            input logic gate, input t_kind kind,
                                            input logic last);
        t_gate_event ev;
        ev.voice    = v[3:0];
        ev.note     = (vc_note[v] == NOTE_IDLE) ? 7'd0 : vc_note[v][6:0];
        ev.velocity = vel;
        ev.gate     = gate;
        ev.kind     = kind;
        ev.last     = last;
        pending_gate_events.push_back(ev);
    endfunction

    function automatic int voice_of_note(input logic [6:0] note);
        for (int i = 0; i < NUM_VOICES; i++)
            if (vc_note[i] == {1'b0, note})
                return i;
        return -1;
    endfunction

    // advance the voice model by one request and queue the gate events it causes
    function automatic void apply_midi_event(input t_opcode op, input logic [6:0] note,
                                             input logic [6:0] vel, input logic pdown,
                                             input logic [3:0] silent);
        int v;
        int last_sus;
        t_kind kind;
        logic [AGE_BITS-1:0] best;
        v = -1;
        last_sus = -1;
        kind = KIND_NONE;
        case (op)
            OP_NOTE_ON: begin
                v = voice_of_note(note);
                if (v < 0) begin
                    for (int i = 0; i < NUM_VOICES && v < 0; i++)
                        if (vc_note[i] == NOTE_IDLE && !vc_releasing[i]) begin
                            v = i;
                            kind = KIND_FREE;
                        end
                end
                if (v < 0) begin
                    for (int i = 0; i < NUM_VOICES && v < 0; i++)
                        if (vc_releasing[i]) begin
                            v = i;
                            kind = KIND_RELEASING;
                        end
                end
                if (v < 0) begin
                    best = '1;
                    v = 0;
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (vc_age[i] < best) begin
                            best = vc_age[i];
                            v = i;
                        end
                    kind = KIND_STOLEN;
                end
                vc_note[v]      = {1'b0, note};
                vc_releasing[v] = 1'b0;
                vc_age[v]       = age_counter;
                age_counter     = age_counter + 1'b1;
                push_gate_event(v, vel, 1'b1, kind, 1'b1);
            end
            OP_NOTE_OFF: begin
                v = voice_of_note(note);
                if (v >= 0) begin
                    if (pedal_held_m) begin
                        vc_sustained[v] = 1'b1;
                    end else begin
                        push_gate_event(v, 7'd0, 1'b0, KIND_NONE, 1'b1);
                        vc_note[v]      = NOTE_IDLE;
                        vc_releasing[v] = 1'b1;
                    end
                end
            end
            OP_PEDAL: begin
                pedal_held_m = pdown;
                if (!pedal_held_m) begin
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (vc_sustained[i])
                            last_sus = i;
                    for (int i = 0; i < NUM_VOICES; i++)
                        if (vc_sustained[i]) begin
                            vc_sustained[i] = 1'b0;
                            push_gate_event(i, 7'd0, 1'b0, KIND_NONE, i == last_sus);
                            vc_note[i]      = NOTE_IDLE;
                            vc_releasing[i] = 1'b1;
                        end
                end
            end
            default: begin
                if (silent < NUM_VOICES)
                    vc_releasing[silent] = 1'b0;
            end
        endcase
    endfunction

    // offer one request, hold it until accepted, then update the model
    task automatic send_event(input t_opcode op, input logic [6:0] note,
                              input logic [6:0] vel, input logic pdown,
                              input logic [3:0] silent);
        if ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_note_number  <= note;
        i_velocity     <= vel;
        i_pedal_down   <= pdown;
        i_silent_voice <= silent;
        do @(posedge i_clk); while (!o_in_ready);
        apply_midi_event(op, note, vel, pdown, silent);
    endtask

    task automatic note_on(input logic [6:0] note, input logic [6:0] vel);
        send_event(OP_NOTE_ON, note, vel, 1'($urandom), 4'($urandom));
    endtask

    task automatic note_off(input logic [6:0] note);
        send_event(OP_NOTE_OFF, note, 7'($urandom), 1'($urandom), 4'($urandom));
    endtask

    task automatic pedal(input logic pdown);
        send_event(OP_PEDAL, 7'($urandom), 7'($urandom), pdown, 4'($urandom));
    endtask

    task automatic release_done(input logic [3:0] silent);
        send_event(OP_REL_DONE, 7'($urandom), 7'($urandom), 1'($urandom), silent);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_gate_events.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_note();
        if ($urandom_range(99) < 70)
            return 7'(48 + $urandom_range(23));
        return 7'($urandom_range(127));
    endfunction

    // weighted mix: note-offs mostly aim at sounding voices, release-dones at releasing ones
    task automatic send_random_event();
        int sel;
        int v;
        int tries;
        sel = $urandom_range(99);
        if (sel < 50) begin
            note_on(pick_note(), 7'($urandom_range(127)));
        end else if (sel < 75) begin
            v = -1;
            if ($urandom_range(99) < 80)
                for (tries = 0; tries < 32 && v < 0; tries++) begin
                    v = $urandom_range(NUM_VOICES - 1);
                    if (vc_note[v] == NOTE_IDLE)
                        v = -1;
                end
            note_off((v >= 0) ? vc_note[v][6:0] : pick_note());
        end else if (sel < 85) begin
            pedal(1'($urandom));
        end else begin
            v = -1;
            if ($urandom_range(99) < 80)
                for (tries = 0; tries < 32 && v < 0; tries++) begin
                    v = $urandom_range(NUM_VOICES - 1);
                    if (!vc_releasing[v])
                        v = -1;
                end
            release_done((v >= 0) ? 4'(v) : 4'($urandom_range(NUM_VOICES - 1)));
        end
    endtask

    task automatic test_note_extremes();
        note_on(7'd0, 7'd0);
        note_on(7'd127, 7'd127);
        note_on(7'd0, 7'd85);
        note_off(7'd42);
        note_off(7'd0);
        note_on(7'd85, 7'd42);
        release_done(4'd0);
        release_done(4'd15);
        note_off(7'd127);
        wait_drain();
    endtask

    task automatic test_sustain_pedal();
        pedal(1'b1);
        note_on(7'd60, 7'd100);
        note_off(7'd60);
        note_off(7'd85);
        note_on(7'd60, 7'd99);
        pedal(1'b1);
        pedal(1'b0);
        pedal(1'b0);
        wait_drain();
    endtask

    // fill every voice, force steals, reuse a releasing one, then steal again
    task automatic test_voice_stealing();
        for (int i = 0; i < NUM_VOICES + 2; i++)
            note_on(7'(i * 7), 7'($urandom_range(127)));
        note_off(7'd21);
        note_on(7'd126, 7'd64);
        note_on(7'd125, 7'd1);
        note_on(7'd124, 7'd2);
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_receiver_holdoff();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = 400;
        pedal(1'b1);
        for (int i = 0; i < 12; i++)
            note_on(pick_note(), 7'($urandom_range(127)));
        for (int i = 0; i < NUM_VOICES; i++)
            if (vc_note[i] != NOTE_IDLE)
                note_off(vc_note[i][6:0]);
        pedal(1'b0);
        for (int i = 0; i < 8; i++)
            send_random_event();
        wait_drain();
    endtask

    task automatic test_random_phase(input int n, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n; i++)
            send_random_event();
        wait_drain();
    endtask

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = 0;
        reset_voice_model();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_NOTE_ON;
        i_note_number  <= '0;
        i_velocity     <= '0;
        i_pedal_down   <= 1'b0;
        i_silent_voice <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_note_extremes();
        test_sustain_pedal();
        test_voice_stealing();
        test_receiver_holdoff();
        test_random_phase(50, 0, 0);
        test_random_phase(50, 84, 0);
        test_random_phase(50, 0, 84);
        test_random_phase(50, 9, 9);

        if (pending_gate_events.size() != 0)
            report_mismatch("outstanding gate events", 0, pending_gate_events.size());
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
